// ===== rtl/m64h_pkg.sv =====
// ----------------------------------------------------------------------------
// m64h_pkg
// Shared types and constants of the streaming 64-bit multiply-xorshift hash.
// ----------------------------------------------------------------------------
package m64h_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  // what one word contributes to the running hash
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PART,
    KIND_FULL
  } kind_t;

  // one classified item, as it travels from the front to the back
  typedef struct packed {
    logic [63:0] word;
    kind_t       kind;
    logic        first;
    logic        last;
    logic [30:0] total_length;
  } item_t;

  // queue side of the back end
  typedef struct packed {
    logic  empty;
    item_t item;
  } q_rd_t;

endpackage

// ===== rtl/m64h_front.sv =====
// ----------------------------------------------------------------------------
// m64h_front
// Accepts input items, masks unused bytes and classifies each word as empty,
// partial or full, then hands it to the queue.
// ----------------------------------------------------------------------------
module m64h_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [63:0]     in_word,
  input  logic [3:0]      in_valid_bytes,
  input  logic            in_first,
  input  logic            in_last,
  input  logic [30:0]     in_total_length,
  output logic            q_push,
  output m64h_pkg::item_t q_item,
  input  logic            q_full
);
  import m64h_pkg::*;

  logic  v_r, v_nxt;
  item_t it_r, it_nxt;
  item_t cls;
  logic  accept;

  // classify and mask the incoming word
  always_comb begin
    cls.first        = in_first;
    cls.last         = in_last;
    cls.total_length = in_total_length;
    if (in_valid_bytes >= 4'd8) begin
      cls.kind = KIND_FULL;
    end else if (in_valid_bytes == 4'd0) begin
      cls.kind = KIND_NONE;
    end else begin
      cls.kind = KIND_PART;
    end
    for (int i = 0; i < 8; i++) begin
      cls.word[i*8 +: 8] = (in_valid_bytes > 4'(i)) ? in_word[i*8 +: 8] : 8'h00;
    end
  end

  assign in_full = v_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = v_r && !q_full;
  assign q_item  = it_r;

  // hold one item until the queue takes it
  always_comb begin
    v_nxt  = v_r;
    it_nxt = it_r;
    if (accept) begin
      v_nxt  = 1'b1;
      it_nxt = cls;
    end else if (q_push) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    it_r <= it_nxt;
  end

endmodule

// ===== rtl/m64h_fifo.sv =====
// ----------------------------------------------------------------------------
// m64h_fifo
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module m64h_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  m64h_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output m64h_pkg::q_rd_t rd
);
  import m64h_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd.empty = (count_r == '0);
  assign rd.item  = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !rd.empty;

  // advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/m64h_mul.sv =====
// ----------------------------------------------------------------------------
// m64h_mul
// Multiplies a 64-bit operand by the mixing constant, modulo 2^64, with one
// 32x32 multiplier, accumulating the low, high-low and low-high products in turn.
// ----------------------------------------------------------------------------
module m64h_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] product
);
  import m64h_pkg::*;

  typedef enum logic [1:0] {
    STEP_LO,
    STEP_HL,
    STEP_LH
  } step_t;

  logic [63:0] a_r, a_nxt;
  logic [63:0] acc_r, acc_nxt;
  step_t       step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] opa, opb;
  logic [63:0] pp, addend;

  // pick the partial product of this step
  always_comb begin
    case (step_r)
      STEP_LO: begin
        opa = a_r[31:0];
        opb = MIX_MUL[31:0];
      end
      STEP_HL: begin
        opa = a_r[63:32];
        opb = MIX_MUL[31:0];
      end
      default: begin
        opa = a_r[31:0];
        opb = MIX_MUL[63:32];
      end
    endcase
    pp     = opa * opb;
    addend = (step_r == STEP_LO) ? pp : {pp[31:0], 32'h0};
  end

  // accumulate, one partial product a cycle
  always_comb begin
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = operand;
      acc_nxt  = '0;
      step_nxt = STEP_LO;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + addend;
      case (step_r)
        STEP_LO: step_nxt = STEP_HL;
        STEP_HL: step_nxt = STEP_LH;
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= STEP_LO;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// ===== rtl/m64h_back.sv =====
// ----------------------------------------------------------------------------
// m64h_back
// Takes classified items from the queue, updates the running hash through
// the shared multiplier and finalizes it on the last word of a message.
// ----------------------------------------------------------------------------
module m64h_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     seed,
  input  m64h_pkg::q_rd_t rd,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [63:0]     out_hash
);
  import m64h_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_BODY,
    S_KEY1,
    S_KEY2,
    S_HMUL,
    S_FIN,
    S_FMUL,
    S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  item_t       it_r, it_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] fin_r, fin_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] oh_r, oh_nxt;
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_p;
  logic [63:0] key, hx;

  m64h_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_a),
    .done    (mul_done),
    .product (mul_p)
  );

  assign key = mul_p ^ (mul_p >> MIX_SHIFT);
  assign hx  = h_r ^ mul_p;

  // sequence one item through the multiplier
  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    h_nxt     = h_r;
    fin_nxt   = fin_r;
    ov_nxt    = ov_r;
    oh_nxt    = oh_r;
    q_pop     = 1'b0;
    mul_start = 1'b0;
    mul_a     = it_r.word;
    if (out_pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (!rd.empty) begin
          q_pop  = 1'b1;
          it_nxt = rd.item;
          if (rd.item.first) begin
            mul_start = 1'b1;
            mul_a     = {33'h0, rd.item.total_length};
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_BODY;
          end
        end
      end
      S_INIT: begin
        if (mul_done) begin
          h_nxt     = {32'h0, seed} ^ mul_p;
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        case (it_r.kind)
          KIND_FULL: begin
            mul_start = 1'b1;
            mul_a     = it_r.word;
            state_nxt = S_KEY1;
          end
          KIND_PART: begin
            h_nxt     = h_r ^ it_r.word;
            mul_start = 1'b1;
            mul_a     = h_r ^ it_r.word;
            state_nxt = S_HMUL;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_KEY1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = key;
          state_nxt = S_KEY2;
        end
      end
      S_KEY2: begin
        if (mul_done) begin
          h_nxt     = hx;
          mul_start = 1'b1;
          mul_a     = hx;
          state_nxt = S_HMUL;
        end
      end
      S_HMUL: begin
        if (mul_done) begin
          h_nxt     = mul_p;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (it_r.last) begin
          mul_start = 1'b1;
          mul_a     = h_r ^ (h_r >> MIX_SHIFT);
          state_nxt = S_FMUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FMUL: begin
        if (mul_done) begin
          fin_nxt   = key;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the result slot to free up
        if (!ov_r || out_pop) begin
          ov_nxt    = 1'b1;
          oh_nxt    = fin_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_empty = !ov_r;
  assign out_hash  = oh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      ov_r    <= ov_nxt;
    end
    it_r  <= it_nxt;
    fin_r <= fin_nxt;
    oh_r  <= oh_nxt;
  end

endmodule

// ===== rtl/murmur64a_stream_hash.sv =====
// ----------------------------------------------------------------------------
// murmur64a_stream_hash
// Streaming 64-bit hash of messages sent as little-endian 64-bit words.
//
//   channel  direction  handshake        payload
//   in_      input      in_push/in_full  word, valid_bytes, first, last, len
//   out_     output     out_empty/pop    hash
//   cfg_     input      cfg_we           32-bit seed
//
// Every 64-bit multiply by the mixing constant runs on the one shared 32x32
// multiplier of the back end; an item needs from no multiply (empty word that
// is neither first nor last) to five (full first and last word).
// The front register and queue keep taking items while the back end works
// or a result waits. Reset clears the seed, the running hash and all queues.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_first,
  input  logic        in_last,
  input  logic [30:0] in_total_length,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_hash,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);
  import m64h_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic        q_push, q_full, q_pop;
  item_t       q_item;
  q_rd_t       q_rd;

  // hold the seed
  assign seed_nxt = cfg_we ? cfg_data : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  m64h_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_word         (in_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_first        (in_first),
    .in_last         (in_last),
    .in_total_length (in_total_length),
    .q_push          (q_push),
    .q_item          (q_item),
    .q_full          (q_full)
  );

  m64h_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .rd        (q_rd)
  );

  m64h_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .rd        (q_rd),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_hash  (out_hash)
  );

endmodule
